FILE: hdl/ffra_pkg.sv
// Shared types and codes for the first-fit range allocator.
package ffra_pkg;

  localparam int SIZE_BITS = 21;
  localparam int LG_BITS   = 4;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RESIZE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

FILE: hdl/first_fit_range_allocator.sv
// First-fit range allocator: sorted allocation table in block memory with a sequencer.
//
// Input channel (in_valid/in_ready) takes one request: action, request_size,
// align_log2, target_offset. Output channel (out_valid/out_ready) returns one
// item per request: status and result_offset (zero on failure or free).
// Config channel (cfg_valid/cfg_ready) writes region_size; always ready.
//
// The table sits in one memory (offset and size arrays on a shared address)
// with one read and one write per cycle and registered read data. Each table
// step is a read state then a check or write state. A resize that must move
// costs the removal sweep plus a fresh allocation.
// One request is worked on at a time; a new one is taken as soon as the
// previous result has moved into the output register.
// Reset clears the entry count and sets region_size to 65536; no memory
// sweep is needed. A stalled receiver holds the output register; the block
// then finishes the next request and waits with its result until the output
// register frees.
module first_fit_range_allocator
  import ffra_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int OFFSET_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SIZE_BITS-1:0]   cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [SIZE_BITS-1:0]   request_size,
  input  logic [LG_BITS-1:0]     align_log2,
  input  logic [OFFSET_BITS-1:0] target_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [OFFSET_BITS-1:0] result_offset
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int IW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = ((OFFSET_BITS > SIZE_BITS) ? OFFSET_BITS : SIZE_BITS) + 3;
  localparam logic [IW-1:0] MAX_CNT = IW'(MAX_ENTRIES);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_ARD  = 12'b000000000010,
    S_ACHK = 12'b000000000100,
    S_AEND = 12'b000000001000,
    S_SRD  = 12'b000000010000,
    S_SWR  = 12'b000000100000,
    S_FRD  = 12'b000001000000,
    S_FCHK = 12'b000010000000,
    S_NRD  = 12'b000100000000,
    S_RSZ  = 12'b001000000000,
    S_RRD  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  state_t state;
  logic [SIZE_BITS-1:0]   region_size;
  logic [IW-1:0]          count;
  logic [IW-1:0]          ptr;
  logic [IW-1:0]          sh;
  logic [CW-1:0]          prev_end;
  logic [OFFSET_BITS-1:0] alloc_off;
  logic [OFFSET_BITS-1:0] ent_off;
  logic [CW-1:0]          next_off;
  logic                   next_pend;
  logic                   moving;
  action_t                act;
  logic [SIZE_BITS-1:0]   req_size;
  logic [LG_BITS-1:0]     req_lg;
  logic [OFFSET_BITS-1:0] req_target;
  status_t                res_status;
  logic [OFFSET_BITS-1:0] res_off;

  logic [OFFSET_BITS-1:0] mem_off  [MAX_ENTRIES];
  logic [SIZE_BITS-1:0]   mem_size [MAX_ENTRIES];
  logic [OFFSET_BITS-1:0] q_off;
  logic [SIZE_BITS-1:0]   q_size;
  logic                   mem_we;
  logic [IW-1:0]          ra_full;
  logic [IW-1:0]          wa_full;
  logic [OFFSET_BITS-1:0] wd_off;
  logic [SIZE_BITS-1:0]   wd_size;

  logic [CW-1:0] amask;
  logic [CW-1:0] cand;
  logic [CW-1:0] cand_end;
  logic [CW-1:0] q_end;
  logic [CW-1:0] span;
  logic [CW-1:0] rend;
  logic [CW-1:0] space;
  logic          sh_done;
  logic          rm_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign span     = CW'(1) << OFFSET_BITS;
  assign rend     = (CW'(region_size) < span) ? CW'(region_size) : span;
  assign amask    = (CW'(1) << req_lg) - CW'(1);
  assign cand     = (prev_end + amask) & ~amask;
  assign cand_end = cand + CW'(req_size);
  assign q_end    = CW'(q_off) + CW'(q_size);
  assign space    = (next_off > CW'(ent_off)) ? next_off - CW'(ent_off) : '0;
  assign sh_done  = (sh == ptr);
  assign rm_last  = ((sh + 1'b1) == count);

  always_comb begin
    mem_we  = 1'b0;
    wa_full = sh;
    wd_off  = q_off;
    wd_size = q_size;
    ra_full = ptr;
    unique case (state)
      S_SRD: begin
        ra_full = sh - 1'b1;
        if (sh_done) begin
          mem_we  = 1'b1;
          wa_full = ptr;
          wd_off  = alloc_off;
          wd_size = req_size;
        end
      end
      S_SWR: mem_we = 1'b1;
      S_NRD: ra_full = ptr + 1'b1;
      S_RSZ: begin
        wa_full = ptr;
        wd_off  = ent_off;
        wd_size = req_size;
        mem_we  = !next_pend && (CW'(req_size) <= space);
      end
      S_RRD: begin
        ra_full = sh + 1'b1;
        mem_we  = next_pend;
        wa_full = sh - 1'b1;
      end
      default: ;
    endcase
  end

  // A read and a write can go out in the same cycle; the read data is then either
  // from a different entry than the one written or not used.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_off[wa_full[AW-1:0]]  <= wd_off;
      mem_size[wa_full[AW-1:0]] <= wd_size;
    end
    q_off  <= mem_off[ra_full[AW-1:0]];
    q_size <= mem_size[ra_full[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      region_size <= SIZE_BITS'(65536);
      count       <= '0;
      out_valid   <= 1'b0;
      next_pend   <= 1'b0;
      moving      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) region_size <= cfg_data;
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act        <= action_t'(action);
            req_size   <= request_size;
            req_lg     <= align_log2;
            req_target <= target_offset;
            ptr        <= '0;
            prev_end   <= '0;
            moving     <= 1'b0;
            res_off    <= '0;
            res_status <= ST_OK;
            unique case (action_t'(action))
              ACT_ALLOC: begin
                if (count >= MAX_CNT) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_ARD;
                end
              end
              ACT_FREE, ACT_RESIZE: state <= S_FRD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_ARD: state <= (ptr == count) ? S_AEND : S_ACHK;
        S_ACHK: begin
          if (cand_end <= CW'(q_off)) begin
            alloc_off <= cand[OFFSET_BITS-1:0];
            sh        <= count;
            state     <= S_SRD;
          end else begin
            if (q_end > prev_end) prev_end <= q_end;
            ptr   <= ptr + 1'b1;
            state <= S_ARD;
          end
        end
        S_AEND: begin
          if (cand_end > rend || cand >= span) begin
            res_status <= ST_NOSPACE;
            state      <= S_DONE;
          end else begin
            alloc_off <= cand[OFFSET_BITS-1:0];
            sh        <= count;
            state     <= S_SRD;
          end
        end
        S_SRD: begin
          if (sh_done) begin
            count   <= count + 1'b1;
            res_off <= alloc_off;
            state   <= S_DONE;
          end else begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          sh    <= sh - 1'b1;
          state <= S_SRD;
        end
        S_FRD: begin
          if (ptr == count) begin
            res_status <= ST_NOTFOUND;
            state      <= S_DONE;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (q_off == req_target) begin
            ent_off <= q_off;
            sh      <= ptr;
            if (act == ACT_FREE) begin
              next_pend <= 1'b0;
              state     <= S_RRD;
            end else begin
              state <= S_NRD;
            end
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_FRD;
          end
        end
        S_NRD: begin
          if ((ptr + 1'b1) < count) begin
            next_pend <= 1'b1;
          end else begin
            next_pend <= 1'b0;
            next_off  <= rend;
          end
          state <= S_RSZ;
        end
        S_RSZ: begin
          if (next_pend) begin
            next_off  <= CW'(q_off);
            next_pend <= 1'b0;
          end else if (CW'(req_size) <= space) begin
            res_off <= ent_off;
            state   <= S_DONE;
          end else begin
            moving <= 1'b1;
            state  <= S_RRD;
          end
        end
        S_RRD: begin
          // next_pend marks read data waiting to be written one slot down
          if (next_pend) begin
            next_pend <= 1'b0;
          end else if (rm_last) begin
            count <= count - 1'b1;
            if (moving) begin
              ptr      <= '0;
              prev_end <= '0;
              state    <= S_ARD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            sh        <= sh + 1'b1;
            next_pend <= 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status        <= res_status;
            result_offset <= (res_status == ST_OK) ? res_off : '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("entry count above table depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("table write while idle");

  a_full_only_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == ST_FULL) |-> (count == MAX_CNT))
    else $error("table full reported with free slots");

endmodule
